// ----- design/keyword_token_scanner_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the keyword token scanner.
// Each macro samples on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define KEYWORD_TOKEN_SCANNER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define KTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition that must never hold.
`define KTS_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`else

`define KTS_ASSERT_IMP(lbl, ante, cons, msg)
`define KTS_ASSERT_NXT(lbl, ante, cons, msg)
`define KTS_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ----- design/kts_pkg.sv -----
// ----------------------------------------------------------------------------
// kts_pkg
// Types, character constants and keyword tables for the keyword token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kts_pkg;

	localparam int MAX_ID_DEF   = 32;
	localparam int POS_BITS_DEF = 16;
	localparam int TOK_W        = 16;
	localparam int NUM_KW       = 4;
	localparam int KW_CHARS     = 5;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_INT,
		MODE_ID,
		MODE_COMMENT
	} mode_t;

	typedef enum logic [3:0] {
		TOK_BEGIN   = 4'd0,
		TOK_END     = 4'd1,
		TOK_ID      = 4'd2,
		TOK_INT     = 4'd3,
		TOK_READ    = 4'd4,
		TOK_WRITE   = 4'd5,
		TOK_ASSIGN  = 4'd6,
		TOK_PLUS    = 4'd7,
		TOK_SEMI    = 4'd8,
		TOK_COMMENT = 4'd9,
		TOK_EOF     = 4'd10,
		TOK_ERROR   = 4'd11
	} tok_t;

	typedef struct packed {
		tok_t             ttype;
		logic [TOK_W-1:0] start;
		logic [TOK_W-1:0] length;
		logic             last;
	} result_t;

	localparam logic [7:0] KW_TEXT [NUM_KW][KW_CHARS] = '{
		'{"b", "e", "g", "i", "n"},
		'{"e", "n", "d", 8'h00, 8'h00},
		'{"w", "r", "i", "t", "e"},
		'{"r", "e", "a", "d", 8'h00}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd5, 3'd3, 3'd5, 3'd4};
	localparam tok_t KW_TYPE [NUM_KW] = '{TOK_BEGIN, TOK_END, TOK_WRITE, TOK_READ};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
	endfunction

	// Drops every keyword that no longer matches once character c sits at index idx.
	function automatic logic [NUM_KW-1:0] kw_next(input logic [NUM_KW-1:0] alive,
			input logic [TOK_W-1:0] idx, input logic [7:0] c);
		logic [NUM_KW-1:0] keep;
		keep = alive;
		for (int k = 0; k < NUM_KW; k++) begin
			if ((idx >= TOK_W'(KW_LEN[k])) || (idx >= TOK_W'(KW_CHARS))) begin
				keep[k] = 1'b0;
			end else if (KW_TEXT[k][idx[2:0]] != c) begin
				keep[k] = 1'b0;
			end
		end
		return keep;
	endfunction

	function automatic tok_t kw_type_of(input logic [NUM_KW-1:0] alive,
			input logic [TOK_W-1:0] len);
		tok_t t;
		t = TOK_ID;
		for (int k = 0; k < NUM_KW; k++) begin
			if (alive[k] && (len == TOK_W'(KW_LEN[k]))) begin
				t = KW_TYPE[k];
			end
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// ----- design/keyword_token_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// keyword_token_scanner_unit
// Scans source text one byte per beat and emits token descriptors with type,
// start offset and length; end of text or a zero byte flushes and emits EOF.
// ----------------------------------------------------------------------------
//
//   channel | handshake           | fields
//   --------+---------------------+----------------------------------------------
//   input   | in_valid / in_stall | kind, ch
//   output  | out_valid/out_stall | token_type, token_start, token_length,
//           |                     | last_of_run
//
// A byte is registered on acceptance and scanned once the queue has room,
// which writes zero, one or two results into a four-entry result queue.
// One byte per cycle is sustained while the receiver takes results as fast as
// they are made; a byte that gives two results puts both in the queue in order.
// The input stalls only when a registered byte waits for two free queue slots.
// Reset clears the scan state, position and queue; no clearing pass is needed.
`default_nettype none
`include "keyword_token_scanner_unit_assert.svh"

module keyword_token_scanner_unit #(
	parameter int MAX_ID   = kts_pkg::MAX_ID_DEF,
	parameter int POS_BITS = kts_pkg::POS_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       kind,
	input  wire logic [7:0]                 ch,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [3:0]                      token_type,
	output logic [kts_pkg::TOK_W-1:0]       token_start,
	output logic [kts_pkg::TOK_W-1:0]       token_length,
	output logic                            last_of_run
);

	localparam int TW = kts_pkg::TOK_W;
	localparam int QDEPTH = 4;
	localparam logic [TW-1:0] MAX_ID_LEN = TW'(MAX_ID);
	localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

	// Input stage.
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] ch_s1;

	// Scan state.
	kts_pkg::mode_t mode_q, mode_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [TW-1:0] pstart_q, pstart_d;
	logic [TW-1:0] plen_q, plen_d;
	logic [kts_pkg::NUM_KW-1:0] alive_q, alive_d;

	// Result queue.
	kts_pkg::result_t queue_q [QDEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;

	logic proc, pop;
	logic [1:0] push_n;
	logic [POS_BITS+TW-1:0] pos_wide;
	logic [TW-1:0] pos16;

	logic is_eof, dig, alpha, grow_int, grow_id, ends, flush_now, sfi_now;
	kts_pkg::tok_t flush_tok;

	kts_pkg::mode_t sfi_mode;
	logic sfi_emit;
	kts_pkg::tok_t sfi_tok;
	logic [kts_pkg::NUM_KW-1:0] sfi_alive;

	kts_pkg::result_t res0, res1;
	logic [1:0] res_n;

	assign proc = valid_s1 && (cnt_q <= 3'd2);
	assign in_stall = valid_s1 && !proc;
	assign pop = out_valid && !out_stall;
	assign push_n = proc ? res_n : 2'd0;

	assign pos_wide = {{TW{1'b0}}, pos_q};
	assign pos16 = pos_wide[TW-1:0];

	// Byte classification and token boundary decisions.
	assign is_eof = kind_s1 || (ch_s1 == kts_pkg::CH_NUL);
	assign dig = kts_pkg::is_digit(ch_s1);
	assign alpha = kts_pkg::is_letter(ch_s1);
	assign grow_int = (mode_q == kts_pkg::MODE_INT) && dig;
	assign grow_id = (mode_q == kts_pkg::MODE_ID) && (dig || alpha) && (plen_q < MAX_ID_LEN);
	assign ends = ((mode_q == kts_pkg::MODE_INT) && !dig) ||
		((mode_q == kts_pkg::MODE_ID) && !grow_id);
	assign flush_now = is_eof ?
		((mode_q == kts_pkg::MODE_INT) || (mode_q == kts_pkg::MODE_ID)) : ends;
	assign sfi_now = !is_eof && ((mode_q == kts_pkg::MODE_IDLE) || ends);
	assign flush_tok = (mode_q == kts_pkg::MODE_ID) ?
		kts_pkg::kw_type_of(alive_q, plen_q) : kts_pkg::TOK_INT;

	// How a byte is taken when no token is pending or the pending token ends on it.
	always_comb begin
		sfi_mode = kts_pkg::MODE_IDLE;
		sfi_emit = 1'b0;
		sfi_tok = kts_pkg::TOK_ERROR;
		sfi_alive = '1;
		if (kts_pkg::is_space(ch_s1)) begin
			sfi_emit = 1'b0;
		end else if (dig) begin
			sfi_mode = kts_pkg::MODE_INT;
		end else if (alpha) begin
			sfi_mode = kts_pkg::MODE_ID;
			sfi_alive = kts_pkg::kw_next('1, '0, ch_s1);
		end else begin
			sfi_emit = 1'b1;
			priority if (ch_s1 == kts_pkg::CH_MINUS) begin
				sfi_tok = kts_pkg::TOK_COMMENT;
				sfi_mode = kts_pkg::MODE_COMMENT;
			end else if (ch_s1 == kts_pkg::CH_EQUAL) begin
				sfi_tok = kts_pkg::TOK_ASSIGN;
			end else if (ch_s1 == kts_pkg::CH_PLUS) begin
				sfi_tok = kts_pkg::TOK_PLUS;
			end else if (ch_s1 == kts_pkg::CH_SEMI) begin
				sfi_tok = kts_pkg::TOK_SEMI;
			end else begin
				sfi_tok = kts_pkg::TOK_ERROR;
			end
		end
	end

	// Next scan state.
	always_comb begin
		mode_d = mode_q;
		pos_d = pos_q;
		pstart_d = pstart_q;
		plen_d = plen_q;
		alive_d = alive_q;
		if (is_eof) begin
			mode_d = kts_pkg::MODE_IDLE;
			pos_d = '0;
			pstart_d = '0;
			plen_d = '0;
			alive_d = '1;
		end else begin
			pos_d = pos_q + POS_ONE;
			priority if (mode_q == kts_pkg::MODE_COMMENT) begin
				if (ch_s1 == kts_pkg::CH_LF) begin
					mode_d = kts_pkg::MODE_IDLE;
				end
			end else if (grow_int) begin
				if (plen_q != '1) begin
					plen_d = plen_q + TW'(1);
				end
			end else if (grow_id) begin
				alive_d = kts_pkg::kw_next(alive_q, plen_q, ch_s1);
				plen_d = plen_q + TW'(1);
			end else begin
				mode_d = sfi_mode;
				if ((sfi_mode == kts_pkg::MODE_INT) || (sfi_mode == kts_pkg::MODE_ID)) begin
					pstart_d = pos16;
					plen_d = TW'(1);
					alive_d = sfi_alive;
				end
			end
		end
	end

	// Results caused by the registered byte, in order.
	always_comb begin
		res0 = '{ttype: kts_pkg::TOK_EOF, start: pos16, length: '0, last: 1'b1};
		res1 = '{ttype: kts_pkg::TOK_EOF, start: pos16, length: '0, last: 1'b1};
		res_n = 2'd0;
		if (flush_now) begin
			res0 = '{ttype: flush_tok, start: pstart_q, length: plen_q, last: 1'b0};
			if (is_eof) begin
				res_n = 2'd2;
			end else if (sfi_now && sfi_emit) begin
				res1 = '{ttype: sfi_tok, start: pos16, length: TW'(1), last: 1'b1};
				res_n = 2'd2;
			end else begin
				res0.last = 1'b1;
				res_n = 2'd1;
			end
		end else if (is_eof) begin
			res_n = 2'd1;
		end else if (sfi_now && sfi_emit) begin
			res0 = '{ttype: sfi_tok, start: pos16, length: TW'(1), last: 1'b1};
			res_n = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= kts_pkg::MODE_IDLE;
			pos_q <= '0;
			pstart_q <= '0;
			plen_q <= '0;
			alive_q <= '1;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (proc) begin
				mode_q <= mode_d;
				pos_q <= pos_d;
				pstart_q <= pstart_d;
				plen_q <= plen_d;
				alive_q <= alive_d;
			end
			wr_ptr_q <= wr_ptr_q + push_n;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			ch_s1 <= ch;
		end
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	assign out_valid = (cnt_q != 3'd0);
	assign token_type = queue_q[rd_ptr_q].ttype;
	assign token_start = queue_q[rd_ptr_q].start;
	assign token_length = queue_q[rd_ptr_q].length;
	assign last_of_run = queue_q[rd_ptr_q].last;

	`KTS_ASSERT_NEVER(a_queue_bound, cnt_q > 3'd4, "result queue overflow")
	`KTS_ASSERT_IMP(a_eof_emits, proc && is_eof, push_n != 2'd0, "end of text gave no result")
	`KTS_ASSERT_NXT(a_eof_resets, proc && is_eof, (mode_q == kts_pkg::MODE_IDLE) && (pos_q == '0), "scan state not cleared after end of text")
	`KTS_ASSERT_IMP(a_id_len, mode_q == kts_pkg::MODE_ID, (plen_q <= MAX_ID_LEN) && (plen_q != '0), "identifier length out of range")

endmodule

`default_nettype wire
